### sv/trpc_pkg.sv
package trpc_pkg;

  localparam int WEIGHT_BITS  = 20;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_VERTEX_A_X = 3'd0;
  localparam cfg_idx_t REG_VERTEX_A_Y = 3'd1;
  localparam cfg_idx_t REG_VERTEX_B_X = 3'd2;
  localparam cfg_idx_t REG_VERTEX_B_Y = 3'd3;
  localparam cfg_idx_t REG_VERTEX_C_X = 3'd4;
  localparam cfg_idx_t REG_VERTEX_C_Y = 3'd5;

endpackage

### sv/triangle_pixel_coverage_barycentric.sv
// Each accepted beat passes through stages 1 to 3, stage 4, the divider stages and the output
// register. Throughput: one beat per cycle unless the output stalls; the weight division is a
// pipelined restoring divider, one quotient bit per stage, each stage taking a new beat each
// cycle while not stalled. A stall at the output freezes the whole pipeline in place.
// Reset (synchronous, rst_n low) zeroes the vertex registers and clears every valid bit.
module triangle_pixel_coverage_barycentric #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  trpc_pkg::cfg_idx_t                      cfg_index,
  input  logic [COORD_BITS-1:0]                   cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [COORD_BITS-1:0]            in_pixel_x,
  input  logic signed [COORD_BITS-1:0]            in_pixel_y,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_inside_res,
  output logic                                    out_covered,
  output logic signed [trpc_pkg::WEIGHT_BITS-1:0] out_weight_a,
  output logic signed [trpc_pkg::WEIGHT_BITS-1:0] out_weight_b,
  output logic signed [trpc_pkg::WEIGHT_BITS-1:0] out_weight_c,
  output logic                                    out_degenerate
);
  import trpc_pkg::*;

  localparam int DF = COORD_BITS + 1;
  localparam int PW = 2 * DF;
  localparam int DW = 2 * DF + 1;
  localparam int QW = WEIGHT_BITS + 1;
  localparam int CW = DW + FRAC_BITS + QW;
  localparam logic [QW-1:0] LIM_POS = QW'((1 << (WEIGHT_BITS - 1)) - 1);
  localparam logic [QW-1:0] LIM_NEG = QW'(1 << (WEIGHT_BITS - 1));

  logic signed [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERTEX_A_X: ax_r <= cfg_data;
        REG_VERTEX_A_Y: ay_r <= cfg_data;
        REG_VERTEX_B_X: bx_r <= cfg_data;
        REG_VERTEX_B_Y: by_r <= cfg_data;
        REG_VERTEX_C_X: cx_r <= cfg_data;
        REG_VERTEX_C_Y: cy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [COORD_BITS-1:0] min3(
    input logic signed [COORD_BITS-1:0] a, b, c);
    logic signed [COORD_BITS-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] max3(
    input logic signed [COORD_BITS-1:0] a, b, c);
    logic signed [COORD_BITS-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  // Stage 1: edge and pixel differences, bounding box test.
  logic v1_r, box1_r;
  logic signed [DF-1:0] bax_r, bay_r, cax_r, cay_r, pax_r, pay_r, cbx_r, cby_r, pbx_r, pby_r;
  logic box_nxt;

  always_comb begin
    box_nxt = (in_pixel_x >= min3(ax_r, bx_r, cx_r)) && (in_pixel_x < max3(ax_r, bx_r, cx_r))
           && (in_pixel_y >= min3(ay_r, by_r, cy_r)) && (in_pixel_y < max3(ay_r, by_r, cy_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bax_r  <= DF'(bx_r) - DF'(ax_r);
      bay_r  <= DF'(by_r) - DF'(ay_r);
      cax_r  <= DF'(cx_r) - DF'(ax_r);
      cay_r  <= DF'(cy_r) - DF'(ay_r);
      pax_r  <= DF'(in_pixel_x) - DF'(ax_r);
      pay_r  <= DF'(in_pixel_y) - DF'(ay_r);
      cbx_r  <= DF'(cx_r) - DF'(bx_r);
      cby_r  <= DF'(cy_r) - DF'(by_r);
      pbx_r  <= DF'(in_pixel_x) - DF'(bx_r);
      pby_r  <= DF'(in_pixel_y) - DF'(by_r);
      box1_r <= box_nxt;
    end
  end

  // Stage 2: the eight products of the four cross products.
  logic v2_r, box2_r;
  logic signed [PW-1:0] pd0_r, pd1_r, pc0_r, pc1_r, pb0_r, pb1_r, pa0_r, pa1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pd0_r  <= bax_r * cay_r;
      pd1_r  <= bay_r * cax_r;
      pc0_r  <= bax_r * pay_r;
      pc1_r  <= bay_r * pax_r;
      pb0_r  <= pax_r * cay_r;
      pb1_r  <= pay_r * cax_r;
      pa0_r  <= cbx_r * pby_r;
      pa1_r  <= cby_r * pbx_r;
      box2_r <= box1_r;
    end
  end

  // Stage 3: determinant and the three weight numerators.
  logic v3_r, box3_r;
  logic signed [DW-1:0] d3_r;
  logic signed [DW-1:0] n3_r [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r    <= DW'(pd0_r) - DW'(pd1_r);
      n3_r[0] <= DW'(pa0_r) - DW'(pa1_r);
      n3_r[1] <= DW'(pb0_r) - DW'(pb1_r);
      n3_r[2] <= DW'(pc0_r) - DW'(pc1_r);
      box3_r  <= box2_r;
    end
  end

  // Stage 4 and the divider stages share these arrays; index 0 is stage 4.
  logic          v_r   [0:QW];
  logic          deg_r [0:QW];
  logic          ins_r [0:QW];
  logic          cov_r [0:QW];
  logic [DW-1:0] dabs_r [0:QW];
  logic [CW-1:0] rem_r [0:QW][0:2];
  logic [QW-1:0] q_r   [0:QW][0:2];
  logic          neg_r [0:QW][0:2];
  logic          ovf_r [0:QW][0:2];

  logic          deg4_nxt, ins4_nxt;
  logic [DW-1:0] dabs4_nxt;
  logic [DW-1:0] mag4;
  logic [CW-1:0] t4_nxt [0:2];
  logic          neg4_nxt [0:2];
  logic          ovf4_nxt [0:2];

  always_comb begin
    deg4_nxt  = (d3_r == '0);
    dabs4_nxt = d3_r[DW-1] ? DW'(-d3_r) : DW'(d3_r);
    ins4_nxt  = 1'b1;
    mag4      = '0;
    for (int i = 0; i < 3; i++) begin
      if ((n3_r[i] != '0) && !deg4_nxt && (n3_r[i][DW-1] != d3_r[DW-1])) begin
        ins4_nxt = 1'b0;
      end
      neg4_nxt[i] = (n3_r[i] != '0) && (n3_r[i][DW-1] != d3_r[DW-1]);
      mag4        = n3_r[i][DW-1] ? DW'(-n3_r[i]) : DW'(n3_r[i]);
      t4_nxt[i]   = (CW'(mag4) << FRAC_BITS) + CW'(dabs4_nxt >> 1);
      ovf4_nxt[i] = t4_nxt[i] >= (CW'(dabs4_nxt) << QW);
    end
  end

  logic [CW-1:0] rem_nxt [1:QW][0:2];
  logic          qbit_nxt [1:QW][0:2];
  logic [CW-1:0] shd;

  always_comb begin
    shd = '0;
    for (int j = 0; j < QW; j++) begin
      shd = CW'(dabs_r[j]) << (QW - 1 - j);
      for (int i = 0; i < 3; i++) begin
        qbit_nxt[j+1][i] = rem_r[j][i] >= shd;
        rem_nxt[j+1][i]  = qbit_nxt[j+1][i] ? (rem_r[j][i] - shd) : rem_r[j][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r[0]  <= deg4_nxt;
      ins_r[0]  <= ins4_nxt;
      cov_r[0]  <= ins4_nxt && box3_r;
      dabs_r[0] <= dabs4_nxt;
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= t4_nxt[i];
        q_r[0][i]   <= '0;
        neg_r[0][i] <= neg4_nxt[i];
        ovf_r[0][i] <= ovf4_nxt[i];
      end
      for (int j = 0; j < QW; j++) begin
        deg_r[j+1]  <= deg_r[j];
        ins_r[j+1]  <= ins_r[j];
        cov_r[j+1]  <= cov_r[j];
        dabs_r[j+1] <= dabs_r[j];
        for (int i = 0; i < 3; i++) begin
          rem_r[j+1][i] <= rem_nxt[j+1][i];
          q_r[j+1][i]   <= {q_r[j][i][QW-2:0], qbit_nxt[j+1][i]};
          neg_r[j+1][i] <= neg_r[j][i];
          ovf_r[j+1][i] <= ovf_r[j][i];
        end
      end
    end
  end

  // Output stage: saturate, apply sign, zero on a degenerate triangle.
  logic signed [WEIGHT_BITS-1:0] w_nxt [0:2];
  logic [QW-1:0] qsat;

  always_comb begin
    qsat = '0;
    for (int i = 0; i < 3; i++) begin
      if (neg_r[QW][i]) begin
        qsat     = (ovf_r[QW][i] || (q_r[QW][i] > LIM_NEG)) ? LIM_NEG : q_r[QW][i];
        w_nxt[i] = WEIGHT_BITS'(-qsat);
      end else begin
        qsat     = (ovf_r[QW][i] || (q_r[QW][i] > LIM_POS)) ? LIM_POS : q_r[QW][i];
        w_nxt[i] = WEIGHT_BITS'(qsat);
      end
      if (deg_r[QW]) begin
        w_nxt[i] = '0;
      end
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside_res <= ins_r[QW];
      out_covered    <= cov_r[QW];
      out_degenerate <= deg_r[QW];
      out_weight_a   <= w_nxt[0];
      out_weight_b   <= w_nxt[1];
      out_weight_c   <= w_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j <= QW; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (en) begin
      v1_r   <= in_valid;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v_r[0] <= v3_r;
      for (int j = 0; j < QW; j++) begin
        v_r[j+1] <= v_r[j];
      end
      out_valid_r <= v_r[QW];
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_weight_a == '0) && (out_weight_b == '0) && (out_weight_c == '0))
    else $error("degenerate result with nonzero weights");
  a_cov_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_covered |-> out_inside_res)
    else $error("covered without inside");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_weight_a) && $stable(out_covered))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("input ready does not follow pipeline stall");
`endif

endmodule
